>>> rtl/core/ldsa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the correction ROM for the log-domain sum accumulator.
package ldsa_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int CORR_TABLE_DEPTH = 513;
   localparam int IDX_SHIFT        = FRAC_BITS - 4;
   localparam int IDX_W            = $clog2(CORR_TABLE_DEPTH);
   localparam int CORR_W           = FRAC_BITS + 1;
   localparam int LOG_W            = 32;
   localparam int DIFF_W           = LOG_W + 1;
   localparam int SUM_W            = LOG_W + 2;
   localparam int PROD_W           = CORR_W + IDX_SHIFT;

   localparam logic signed [LOG_W-1:0] SUM_MAX = {1'b0, {(LOG_W-1){1'b1}}};

   typedef logic [CORR_W-1:0] corr_entry_type;
   typedef corr_entry_type corr_table_type [CORR_TABLE_DEPTH];

   // bitwise integer square root, 64-bit
   function automatic logic [63:0] isqrt_u64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 30;
   endfunction

   // log2 of z in Q30, 1 <= z <= 2, one fraction bit per squaring
   function automatic logic [63:0] log2_q30(input logic [63:0] z_in);
      logic [63:0] z;
      logic [63:0] acc;
      z   = z_in;
      acc = 64'd0;
      if (z >= (64'd2 << 30)) begin
         acc = 64'd1 << 30;
         z   = z >> 1;
      end
      for (int i = 29; i >= 0; i--) begin
         z = mul_q30(z, z);
         if (z >= (64'd2 << 30)) begin
            z   = z >> 1;
            acc = acc | (64'd1 << i);
         end
      end
      return acc;
   endfunction

   // T[k] = round(2^FRAC_BITS * log2(1 + 2^(-k/16))), evaluated at elaboration
   function automatic corr_table_type build_corr_table();
      corr_table_type tbl;
      logic [63:0]    root [4];
      logic [63:0]    frac_pow [16];
      logic [63:0]    p;
      logic [63:0]    y;
      logic [63:0]    lg;
      int             sh;
      root[0] = isqrt_u64((64'd1 << 29) << 30);
      for (int j = 1; j < 4; j++) begin
         root[j] = isqrt_u64(root[j-1] << 30);
      end
      for (int m = 0; m < 16; m++) begin
         p = 64'd1 << 30;
         for (int j = 0; j < 4; j++) begin
            if (((m >> (3 - j)) & 1) != 0) begin
               p = mul_q30(p, root[j]);
            end
         end
         frac_pow[m] = p;
      end
      for (int k = 0; k < CORR_TABLE_DEPTH; k++) begin
         sh = k >> 4;
         y  = (sh >= 31) ? 64'd0 : (frac_pow[k & 15] >> sh);
         lg = log2_q30((64'd1 << 30) + y);
         lg = (lg + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         tbl[k] = lg[CORR_W-1:0];
      end
      return tbl;
   endfunction

   localparam corr_table_type CORR_TABLE = build_corr_table();

endpackage

>>> rtl/core/log2_domain_sum_accumulator_core.sv
`timescale 1ns / 1ps
// Log-domain sum accumulator: sum = max(sum, x) + log2(1 + 2^-|sum - x|), saturating; a first item loads x.
// A request passes through the input register and then the result register before rsp_valid.
// The block takes one request per cycle unless rsp_stall holds a full result register; the running-sum
// feedback (subtract, ROM read, interpolation multiply, add and clip) is combinational.
// Reset (synchronous, active high) empties both registers and clears sum and flag.
module log2_domain_sum_accumulator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ldsa_pkg::LOG_W-1:0] req_log_value,
   input  logic                          req_first,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ldsa_pkg::LOG_W-1:0] rsp_log_sum,
   output logic                          rsp_run_done,
   output logic                          rsp_saturated
);

   // input register
   logic                                 in_valid_ff, in_valid_in;
   logic signed [ldsa_pkg::LOG_W-1:0]    in_value_ff;
   logic                                 in_first_ff;
   logic                                 in_last_ff;

   // accumulator state
   logic signed [ldsa_pkg::LOG_W-1:0]    sum_ff, sum_in;
   logic                                 sat_ff, sat_in;

   // result register
   logic                                 out_valid_ff, out_valid_in;
   logic signed [ldsa_pkg::LOG_W-1:0]    out_sum_ff;
   logic                                 out_last_ff;
   logic                                 out_sat_ff;

   logic                                 fire;
   logic                                 req_take;
   logic signed [ldsa_pkg::DIFF_W-1:0]   diff;
   logic        [ldsa_pkg::LOG_W-1:0]    abs_diff;
   logic        [ldsa_pkg::LOG_W-ldsa_pkg::IDX_SHIFT-1:0] tbl_k;
   logic        [ldsa_pkg::IDX_W-1:0]    k_lo, k_hi;
   logic        [ldsa_pkg::IDX_SHIFT-1:0] frac;
   logic        [ldsa_pkg::CORR_W-1:0]   t_hi, t_lo, t_step;
   logic        [ldsa_pkg::PROD_W:0]     prod;
   logic        [ldsa_pkg::CORR_W-1:0]   drop;
   logic        [ldsa_pkg::CORR_W-1:0]   corr;
   logic signed [ldsa_pkg::LOG_W-1:0]    big;
   logic signed [ldsa_pkg::SUM_W-1:0]    raw_sum;
   logic                                 clip;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // correction: linear interpolation between neighbouring ROM entries
   always_comb begin
      diff     = ldsa_pkg::DIFF_W'(sum_ff) - ldsa_pkg::DIFF_W'(in_value_ff);
      abs_diff = diff[ldsa_pkg::DIFF_W-1] ? ldsa_pkg::LOG_W'(-diff)
                                          : diff[ldsa_pkg::LOG_W-1:0];
      tbl_k  = abs_diff[ldsa_pkg::LOG_W-1:ldsa_pkg::IDX_SHIFT];
      frac   = abs_diff[ldsa_pkg::IDX_SHIFT-1:0];
      k_lo   = tbl_k[ldsa_pkg::IDX_W-1:0];
      k_hi   = k_lo + 1'b1;
      t_hi   = ldsa_pkg::CORR_TABLE[k_lo];
      t_lo   = ldsa_pkg::CORR_TABLE[k_hi];
      t_step = t_hi - t_lo;
      prod   = (ldsa_pkg::PROD_W+1)'(t_step) * (ldsa_pkg::PROD_W+1)'(frac)
             + ((ldsa_pkg::PROD_W+1)'(1) << (ldsa_pkg::IDX_SHIFT - 1));
      drop   = prod[ldsa_pkg::IDX_SHIFT +: ldsa_pkg::CORR_W];
      // far apart: the smaller term no longer shows
      if (tbl_k >= (ldsa_pkg::LOG_W-ldsa_pkg::IDX_SHIFT)'(ldsa_pkg::CORR_TABLE_DEPTH - 1)) begin
         corr = '0;
      end else begin
         corr = t_hi - drop;
      end
      big     = (sum_ff > in_value_ff) ? sum_ff : in_value_ff;
      raw_sum = ldsa_pkg::SUM_W'(big) + $signed({1'b0, (ldsa_pkg::SUM_W-1)'(corr)});
      clip    = raw_sum > ldsa_pkg::SUM_W'(ldsa_pkg::SUM_MAX);
   end

   always_comb begin
      sum_in = sum_ff;
      sat_in = sat_ff;
      if (fire) begin
         if (in_first_ff) begin
            sum_in = in_value_ff;
            sat_in = 1'b0;
         end else if (clip) begin
            sum_in = ldsa_pkg::SUM_MAX;
            sat_in = 1'b1;
         end else begin
            sum_in = raw_sum[ldsa_pkg::LOG_W-1:0];
         end
      end
   end

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff <= req_log_value;
         in_first_ff <= req_first;
         in_last_ff  <= req_last;
      end
      if (fire) begin
         out_sum_ff  <= sum_in;
         out_last_ff <= in_last_ff;
         out_sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_log_sum   = out_sum_ff;
   assign rsp_run_done  = out_last_ff;
   assign rsp_saturated = out_sat_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   a_first_clears_sat: assert property (@(posedge clock) disable iff (reset)
      fire && in_first_ff |=> !rsp_saturated && rsp_valid)
      else $error("run start did not clear saturation flag");

   a_clip_at_max: assert property (@(posedge clock) disable iff (reset)
      fire && !in_first_ff && clip |=> rsp_log_sum == ldsa_pkg::SUM_MAX && rsp_saturated)
      else $error("overflow did not clip to maximum");

   a_sum_not_below_max_operand: assert property (@(posedge clock) disable iff (reset)
      fire && !in_first_ff |=> rsp_log_sum >= $past(big))
      else $error("log sum below larger operand");

endmodule

>>> tb/tb_log2_domain_sum_accumulator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the base-2 log-domain sum accumulator core.
module tb_log2_domain_sum_accumulator_core;

   localparam int     LW          = ldsa_pkg::LOG_W;
   localparam longint LOG_MAX     = 64'sd2147483647;
   localparam longint LOG_MIN     = -LOG_MAX - 1;
   localparam int     CYCLE_LIMIT = 200000;
   localparam int     RANDOM_REQS = 600;

   typedef struct {
      logic signed [LW-1:0] log_sum;
      logic                 run_done;
      logic                 saturated;
   } log_sum_result_type;

   // running log-sum predictor plus the queue of sums still owed by the block
   class log_sum_scoreboard;
      localparam bit [63:0] Q30_ONE = 64'd1 << 30;
      localparam bit [63:0] Q30_TWO = 64'd2 << 30;

      bit [31:0]          corr_rom [ldsa_pkg::CORR_TABLE_DEPTH];
      longint             sum_q;
      bit                 sat_q;
      log_sum_result_type expected_q [$];
      int                 errors;
      int                 n_requests;
      int                 n_checked;
      int                 n_runs;
      int                 n_clips;
      int                 n_far;

      function new();
         bit [63:0] root [4];
         bit [63:0] frac_pow [16];
         bit [63:0] p;
         bit [63:0] y;
         bit [63:0] lg;
         int        sh;
         // 2^-1/2 .. 2^-1/16 in Q30 by repeated square roots
         root[0] = floor_sqrt((Q30_ONE >> 1) << 30);
         for (int j = 1; j < 4; j++) root[j] = floor_sqrt(root[j-1] << 30);
         for (int m = 0; m < 16; m++) begin
            p = Q30_ONE;
            for (int j = 0; j < 4; j++) begin
               if (m[3-j]) p = (p * root[j]) >> 30;
            end
            frac_pow[m] = p;
         end
         for (int k = 0; k < ldsa_pkg::CORR_TABLE_DEPTH; k++) begin
            sh = k >> 4;
            y  = (sh >= 31) ? 64'd0 : (frac_pow[k % 16] >> sh);
            lg = q30_log2(Q30_ONE + y);
            lg = (lg + (64'd1 << (29 - ldsa_pkg::FRAC_BITS))) >> (30 - ldsa_pkg::FRAC_BITS);
            corr_rom[k] = lg[31:0];
         end
         sum_q = 0;
         sat_q = 1'b0;
         errors = 0;
         n_requests = 0;
         n_checked = 0;
         n_runs = 0;
         n_clips = 0;
         n_far = 0;
      endfunction

      function bit [63:0] floor_sqrt(bit [63:0] v);
         bit [63:0] r;
         bit [63:0] cand;
         r = 64'd0;
         for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v) r = cand;
         end
         return r;
      endfunction

      // z in [1, 2] as Q30; one fraction bit per squaring
      function bit [63:0] q30_log2(bit [63:0] z);
         bit [63:0] acc;
         acc = 64'd0;
         if (z >= Q30_TWO) begin
            acc = Q30_ONE;
            z   = z >> 1;
         end
         for (int i = 29; i >= 0; i--) begin
            z = (z * z) >> 30;
            if (z >= Q30_TWO) begin
               z   = z >> 1;
               acc = acc | (64'd1 << i);
            end
         end
         return acc;
      endfunction

      function longint corr_value(bit [63:0] d);
         bit [63:0] k;
         bit [63:0] f;
         bit [63:0] hi;
         bit [63:0] lo;
         bit [63:0] drop;
         k = d >> ldsa_pkg::IDX_SHIFT;
         f = d & ((64'd1 << ldsa_pkg::IDX_SHIFT) - 1);
         if (k >= ldsa_pkg::CORR_TABLE_DEPTH - 1) return 0;
         hi   = corr_rom[k];
         lo   = corr_rom[k+1];
         drop = ((hi - lo) * f + (64'd1 << (ldsa_pkg::IDX_SHIFT - 1))) >> ldsa_pkg::IDX_SHIFT;
         return longint'(hi - drop);
      endfunction

      function void note_request(logic signed [LW-1:0] x, logic first, logic last);
         longint             xv;
         longint             top;
         longint             diff;
         longint             nxt;
         bit [63:0]          d;
         log_sum_result_type r;
         xv = x;
         n_requests++;
         if (first) begin
            sum_q = xv;
            sat_q = 1'b0;
            n_runs++;
         end else begin
            top  = (sum_q > xv) ? sum_q : xv;
            diff = sum_q - xv;
            d    = (diff < 0) ? -diff : diff;
            if ((d >> ldsa_pkg::IDX_SHIFT) >= ldsa_pkg::CORR_TABLE_DEPTH - 1) n_far++;
            nxt = top + corr_value(d);
            if (nxt > LOG_MAX) begin
               nxt   = LOG_MAX;
               sat_q = 1'b1;
               n_clips++;
            end
            sum_q = nxt;
         end
         r.log_sum   = sum_q[LW-1:0];
         r.run_done  = last;
         r.saturated = sat_q;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [LW-1:0] log_sum, logic run_done, logic saturated);
         log_sum_result_type e;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding: log_sum=%0d", log_sum);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         n_checked++;
         if (log_sum !== e.log_sum) begin
            $error("log_sum: expected %0d, got %0d", e.log_sum, log_sum);
            errors++;
         end
         if (run_done !== e.run_done) begin
            $error("run_done: expected %0b, got %0b", e.run_done, run_done);
            errors++;
         end
         if (saturated !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [LW-1:0] req_log_value = '0;
   logic                 req_first = 1'b0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [LW-1:0] rsp_log_sum;
   logic                 rsp_run_done;
   logic                 rsp_saturated;

   log_sum_scoreboard sb;
   int                burst_left = 0;
   int                req_accepted = 0;
   int                long_holds = 0;
   int                cycle_count = 0;

   log2_domain_sum_accumulator_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_log_value (req_log_value),
      .req_first     (req_first),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_log_sum   (rsp_log_sum),
      .rsp_run_done  (rsp_run_done),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                  sb.expected_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // requests are noted before results are checked in the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_log_value, req_first, req_last);
            req_accepted++;
         end
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_log_sum, rsp_run_done, rsp_saturated);
      end
   end

   function automatic logic signed [LW-1:0] to_log_range(longint v);
      if (v > LOG_MAX) return LOG_MAX[LW-1:0];
      if (v < LOG_MIN) return LOG_MIN[LW-1:0];
      return v[LW-1:0];
   endfunction

   // sender: bursts of random length, random gaps between them
   task automatic send_request(input logic signed [LW-1:0] v, input logic f, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_log_value <= v;
      req_first     <= f;
      req_last      <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: own stall pattern, plus long hold-offs to back the block up
   initial begin : rsp_side
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (long_holds < 2 && req_accepted > 150 + 250 * long_holds) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_holds++;
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int     sent;
      int     len;
      int     style;
      int     off;
      bit     drop_last;
      longint centre;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no run started yet: accumulates into the reset sum
      send_request(0, 1'b0, 1'b0);
      // single-term run at the most negative value
      send_request(LOG_MIN[LW-1:0], 1'b1, 1'b1);
      // overflow clips, then a far smaller term leaves sum and flag alone
      send_request(LOG_MAX[LW-1:0], 1'b1, 1'b0);
      send_request(LOG_MAX[LW-1:0], 1'b0, 1'b0);
      send_request(LOG_MIN[LW-1:0], 1'b0, 1'b1);
      // term after a last item still accumulates
      send_request(0, 1'b0, 1'b0);
      // difference of exactly 32: past the table, no correction
      send_request(0, 1'b1, 1'b0);
      send_request(32'sd32 << 16, 1'b0, 1'b0);
      // just below 32: last table segment, fraction all ones
      send_request(0, 1'b1, 1'b0);
      send_request((32'sd32 << 16) - 1, 1'b0, 1'b0);
      // equal operands
      send_request(0, 1'b1, 1'b0);
      send_request(0, 1'b0, 1'b1);
      send_request(LOG_MIN[LW-1:0], 1'b1, 1'b0);
      send_request(LOG_MIN[LW-1:0], 1'b0, 1'b1);
      // clip from just below the top, then a new run clears the flag
      send_request(LOG_MAX[LW-1:0] - 100, 1'b1, 1'b0);
      send_request(LOG_MAX[LW-1:0] - 100, 1'b0, 1'b0);
      send_request(32'sh5555_5555, 1'b1, 1'b1);
      send_request(32'shAAAA_AAAA, 1'b1, 1'b0);
      send_request(0, 1'b1, 1'b0);
      send_request(32'sh0000_0FFF, 1'b0, 1'b0);
      send_request(-(32'sd5 << 16) - 123, 1'b0, 1'b1);

      sent = 0;
      while (sent < RANDOM_REQS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            style = $urandom_range(0, 4);
            case (style)
               0:       centre = LOG_MAX - longint'($urandom_range(0, 8 << 16));
               1:       centre = LOG_MIN + longint'($urandom_range(0, 8 << 16));
               2:       centre = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
               default: centre = longint'($signed($urandom));
            endcase
            len       = $urandom_range(1, 12);
            drop_last = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  off = $signed($urandom);
               end else begin
                  off = $urandom_range(0, 68 << 16);
                  off = off - (34 << 16);
               end
               send_request(to_log_range(centre + off), i == 0, (i == len - 1) && !drop_last);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d requests in %0d runs: %0d clipped sums, %0d updates past the table",
               sb.n_requests, sb.n_runs, sb.n_clips, sb.n_far);
      $display("%0d results checked, %0d long output hold-offs, %0d mismatches",
               sb.n_checked, long_holds, sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
